FILE: src/qau_pkg.sv
`timescale 1ns / 1ps

package qau_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    typedef enum logic [2:0] {
        FN_MUL  = 3'd0,
        FN_CONJ = 3'd1,
        FN_INV  = 3'd2,
        FN_NORM = 3'd3,
        FN_LEN  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0] func;
        logic       zs;
        logic       dz;
        logic       carry;
    } ctrl_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } lane_res_t;

    typedef struct packed {
        logic [DATA_W-1:0] early;
        logic              esat;
        logic [DATA_W-1:0] amag;
        logic              qsign;
        logic              usediv;
    } lane_pay_t;

    // hamilton product terms per output component (w, x, y, z)
    localparam logic [1:0] TERM_A [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}
    };
    localparam logic [1:0] TERM_B [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1}
    };
    localparam logic [3:0] TERM_NEG [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

endpackage

FILE: src/qau_if.sv
`timescale 1ns / 1ps

interface qau_op_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;

    modport source (output valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    input ready);
    modport sink (input valid, func, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  output ready);
endinterface

interface qau_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic [31:0]        magnitude;
    logic [1:0]         status;

    modport source (output valid, r_w, r_x, r_y, r_z, magnitude, status,
                    input ready);
    modport sink (input valid, r_w, r_x, r_y, r_z, magnitude, status,
                  output ready);
endinterface

FILE: src/qau_sqrt.sv
`timescale 1ns / 1ps

module qau_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] s,
    output logic [31:0] root
);
    import qau_pkg::*;

    logic [63:0] v_reg   [SQRT_STAGES];
    logic [63:0] res_reg [SQRT_STAGES];

    // one result bit per stage, restoring digit recurrence
    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
        logic [63:0] v_in;
        logic [63:0] r_in;
        logic [63:0] trial;
        logic        ge;

        if (j == 0) begin : g_first
            assign v_in = s;
            assign r_in = '0;
        end
        else begin : g_next
            assign v_in = v_reg[j-1];
            assign r_in = res_reg[j-1];
        end

        assign trial = r_in + BIT;
        assign ge    = v_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j]   <= ge ? v_in - trial : v_in;
                res_reg[j] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
            end
        end
    end

    assign root = res_reg[SQRT_STAGES-1][31:0];

endmodule

FILE: src/qau_lane.sv
`timescale 1ns / 1ps

module qau_lane #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [2:0]             func,
    input  logic signed [31:0]     ma [4],
    input  logic signed [31:0]     mb [4],
    input  logic [3:0]             neg,
    input  logic signed [31:0]     a_c,
    input  logic                   scalar,
    input  logic [64-FRAC_BITS:0]  divisor,
    output qau_pkg::lane_res_t     res
);
    import qau_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int DIV_W = 65 - FRAC_BITS;
    localparam int CMP_W = DIV_W + DATA_W;

    logic signed [63:0] prod_s1_reg [4];
    logic signed [31:0] a_s1_reg;
    logic [2:0]         func_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < 4; t++)
            begin
                prod_s1_reg[t] <= ma[t] * mb[t];
            end
            a_s1_reg    <= a_c;
            func_s1_reg <= func;
        end
    end

    logic signed [65:0] sum_c;
    logic signed [65:0] shf_c;
    logic [31:0]        mul_c;
    logic               mul_sat_c;
    logic [31:0]        conj_c;
    logic               conj_sat_c;
    lane_pay_t          pay_c;

    always_comb
    begin
        sum_c = '0;
        for (int t = 0; t < 4; t++)
        begin
            if (neg[t])
            begin
                sum_c = sum_c - 66'(prod_s1_reg[t]);
            end
            else
            begin
                sum_c = sum_c + 66'(prod_s1_reg[t]);
            end
        end
        // arithmetic shift gives the floor
        shf_c = sum_c >>> FRAC_BITS;
        if (shf_c > 66'sd2147483647)
        begin
            mul_c     = 32'h7fff_ffff;
            mul_sat_c = 1'b1;
        end
        else if (shf_c < -66'sd2147483648)
        begin
            mul_c     = 32'h8000_0000;
            mul_sat_c = 1'b1;
        end
        else
        begin
            mul_c     = shf_c[31:0];
            mul_sat_c = 1'b0;
        end

        if (scalar)
        begin
            conj_c     = a_s1_reg;
            conj_sat_c = 1'b0;
        end
        else if (a_s1_reg == 32'sh8000_0000)
        begin
            conj_c     = 32'h7fff_ffff;
            conj_sat_c = 1'b1;
        end
        else
        begin
            conj_c     = 32'd0 - a_s1_reg;
            conj_sat_c = 1'b0;
        end

        pay_c.early = (func_s1_reg == FN_MUL) ? mul_c : conj_c;
        pay_c.esat  = (func_s1_reg == FN_MUL) ? mul_sat_c : conj_sat_c;
        pay_c.amag  = a_s1_reg[31] ? (32'd0 - a_s1_reg) : a_s1_reg;
        // inverse negates the vector part, so its sign flips there
        if (func_s1_reg == FN_NORM || scalar)
        begin
            pay_c.qsign = a_s1_reg[31];
        end
        else
        begin
            pay_c.qsign = !a_s1_reg[31] && (a_s1_reg != 32'sd0);
        end
        pay_c.usediv = (func_s1_reg == FN_INV) || (func_s1_reg == FN_NORM);
    end

    // wait for the root
    lane_pay_t l_pay_reg [SQRT_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_pay_reg[0] <= pay_c;
            for (int j = 1; j <= SQRT_STAGES; j++)
            begin
                l_pay_reg[j] <= l_pay_reg[j-1];
            end
        end
    end

    // divider: overflow check, then one quotient bit per stage
    logic [NUM_W-1:0] d_rem_reg [DIV_STAGES];
    logic [DIV_W-1:0] d_div_reg [DIV_STAGES];
    logic [31:0]      d_q_reg   [DIV_STAGES+1];
    logic             d_ovf_reg [DIV_STAGES+1];
    lane_pay_t        d_pay_reg [DIV_STAGES+1];

    lane_pay_t l_last;
    assign l_last = l_pay_reg[SQRT_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_rem_reg[0] <= {l_last.amag, {FRAC_BITS{1'b0}}};
            d_div_reg[0] <= divisor;
            d_ovf_reg[0] <= DIV_W'(l_last.amag >> (DATA_W - FRAC_BITS)) >= divisor;
            d_q_reg[0]   <= '0;
            d_pay_reg[0] <= l_last;
        end
    end

    for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
        localparam int K = DIV_STAGES - j;
        logic [CMP_W-1:0] trial;
        logic             ge;

        assign trial = CMP_W'(d_div_reg[j-1]) << K;
        assign ge    = CMP_W'(d_rem_reg[j-1]) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_q_reg[j]   <= {d_q_reg[j-1][30:0], ge};
                d_ovf_reg[j] <= d_ovf_reg[j-1];
                d_pay_reg[j] <= d_pay_reg[j-1];
            end
        end

        if (j < DIV_STAGES) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_rem_reg[j] <= ge ? d_rem_reg[j-1] - trial[NUM_W-1:0] : d_rem_reg[j-1];
                    d_div_reg[j] <= d_div_reg[j-1];
                end
            end
        end
    end

    lane_pay_t   f_pay;
    logic [31:0] f_q;
    logic        f_ovf;

    assign f_pay = d_pay_reg[DIV_STAGES];
    assign f_q   = d_q_reg[DIV_STAGES];
    assign f_ovf = d_ovf_reg[DIV_STAGES];

    always_comb
    begin
        if (!f_pay.usediv)
        begin
            res.value = f_pay.early;
            res.sat   = f_pay.esat;
        end
        else if (f_pay.qsign)
        begin
            if (f_ovf || f_q > 32'h8000_0000)
            begin
                res.value = 32'h8000_0000;
                res.sat   = 1'b1;
            end
            else
            begin
                res.value = 32'd0 - f_q;
                res.sat   = 1'b0;
            end
        end
        else if (f_ovf || f_q[31])
        begin
            res.value = 32'h7fff_ffff;
            res.sat   = 1'b1;
        end
        else
        begin
            res.value = f_q;
            res.sat   = 1'b0;
        end
    end

endmodule

FILE: src/qau_merge.sv
`timescale 1ns / 1ps

module qau_merge #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS
) (
    input  logic               clk,
    input  logic               en,
    input  qau_pkg::ctrl_t     ctrl,
    input  logic [31:0]        mag,
    input  qau_pkg::lane_res_t lane [4],
    output logic [31:0]        r_reg [4],
    output logic [31:0]        magnitude_reg,
    output logic [1:0]         status_reg
);
    import qau_pkg::*;

    logic [31:0] r_next [4];
    status_t     status_next;
    logic        any_sat;

    assign any_sat = lane[0].sat || lane[1].sat || lane[2].sat || lane[3].sat;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            r_next[i] = '0;
        end
        status_next = ST_OK;
        unique case (ctrl.func)
            FN_MUL, FN_CONJ:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    r_next[i] = lane[i].value;
                end
                status_next = any_sat ? ST_SAT : ST_OK;
            end
            FN_INV:
            begin
                if (ctrl.dz)
                begin
                    status_next = ST_ZERO;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        r_next[i] = lane[i].value;
                    end
                    status_next = any_sat ? ST_SAT : ST_OK;
                end
            end
            FN_NORM:
            begin
                if (ctrl.zs)
                begin
                    // zero input maps to the identity
                    r_next[0]   = 32'(1) << FRAC_BITS;
                    status_next = ST_ZERO;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        r_next[i] = lane[i].value;
                    end
                end
            end
            FN_LEN:
            begin
                if (ctrl.zs)
                begin
                    status_next = ST_ZERO;
                end
                else if (ctrl.carry)
                begin
                    status_next = ST_SAT;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r_reg[i] <= r_next[i];
            end
            magnitude_reg <= mag;
            status_reg    <= status_next;
        end
    end

endmodule

FILE: src/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps
// channel   dir  payload
// operand   in   func, a_w..a_z, b_w..b_z
// result    out  r_w..r_z, magnitude, status
//
// one word accepted per cycle while the output is not stalled, results in order
// pipeline: 2 front stages, 32-stage square root, overflow check,
// 32-stage divider per lane, output register
// the whole pipeline holds while a result waits and result.ready is low
// reset clears the valid bits only

module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    qau_op_if.sink    operand,
    qau_res_if.source result
);
    import qau_pkg::*;

    localparam int DIV_W = 65 - FRAC_BITS;

    logic en;
    logic out_vld_reg;

    assign en            = !out_vld_reg || result.ready;
    assign operand.ready = en;

    logic signed [31:0] a_arr [4];
    logic signed [31:0] b_arr [4];

    assign a_arr[0] = operand.a_w;
    assign a_arr[1] = operand.a_x;
    assign a_arr[2] = operand.a_y;
    assign a_arr[3] = operand.a_z;
    assign b_arr[0] = operand.b_w;
    assign b_arr[1] = operand.b_x;
    assign b_arr[2] = operand.b_y;
    assign b_arr[3] = operand.b_z;

    // squares of a
    logic               vld_s1_reg;
    logic [2:0]         func_s1_reg;
    logic [62:0]        sq_s1_reg [4];
    logic signed [63:0] sq_full [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_full[i] = a_arr[i] * a_arr[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func_s1_reg <= operand.func;
            for (int i = 0; i < 4; i++)
            begin
                sq_s1_reg[i] <= sq_full[i][62:0];
            end
        end
    end

    // sum of squares, 65 bits exact
    logic [64:0]      s_sum;
    logic             vld_s2_reg;
    ctrl_t            ctrl_s2_reg;
    logic [63:0]      s_s2_reg;
    logic [DIV_W-1:0] dotq_s2_reg;
    ctrl_t            ctrl_next;

    assign s_sum = 65'(sq_s1_reg[0]) + 65'(sq_s1_reg[1]) + 65'(sq_s1_reg[2])
                 + 65'(sq_s1_reg[3]);

    always_comb
    begin
        ctrl_next.func  = func_s1_reg;
        ctrl_next.zs    = s_sum == '0;
        ctrl_next.dz    = s_sum[64:FRAC_BITS] == '0;
        ctrl_next.carry = s_sum[64];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_s2_reg <= ctrl_next;
            s_s2_reg    <= s_sum[63:0];
            dotq_s2_reg <= s_sum[64:FRAC_BITS];
        end
    end

    logic [31:0] root;

    qau_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .s    (s_s2_reg),
        .root (root)
    );

    logic             p_vld_reg  [SQRT_STAGES];
    ctrl_t            p_ctrl_reg [SQRT_STAGES];
    logic [DIV_W-1:0] p_dotq_reg [SQRT_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ctrl_reg[0] <= ctrl_s2_reg;
            p_dotq_reg[0] <= dotq_s2_reg;
            for (int j = 1; j < SQRT_STAGES; j++)
            begin
                p_ctrl_reg[j] <= p_ctrl_reg[j-1];
                p_dotq_reg[j] <= p_dotq_reg[j-1];
            end
        end
    end

    ctrl_t            p_last;
    logic [31:0]      mag_c;
    logic [DIV_W-1:0] divisor_c;

    assign p_last    = p_ctrl_reg[SQRT_STAGES-1];
    assign mag_c     = p_last.carry ? 32'hffff_ffff : root;
    assign divisor_c = (p_last.func == FN_NORM) ? DIV_W'(mag_c)
                                                : p_dotq_reg[SQRT_STAGES-1];

    logic        q_vld_reg  [DIV_STAGES+1];
    ctrl_t       q_ctrl_reg [DIV_STAGES+1];
    logic [31:0] q_mag_reg  [DIV_STAGES+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_ctrl_reg[0] <= p_last;
            q_mag_reg[0]  <= mag_c;
            for (int j = 1; j <= DIV_STAGES; j++)
            begin
                q_ctrl_reg[j] <= q_ctrl_reg[j-1];
                q_mag_reg[j]  <= q_mag_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg  <= 1'b0;
            vld_s2_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int j = 0; j < SQRT_STAGES; j++)
            begin
                p_vld_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= DIV_STAGES; j++)
            begin
                q_vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_s1_reg   <= operand.valid;
            vld_s2_reg   <= vld_s1_reg;
            p_vld_reg[0] <= vld_s2_reg;
            for (int j = 1; j < SQRT_STAGES; j++)
            begin
                p_vld_reg[j] <= p_vld_reg[j-1];
            end
            q_vld_reg[0] <= p_vld_reg[SQRT_STAGES-1];
            for (int j = 1; j <= DIV_STAGES; j++)
            begin
                q_vld_reg[j] <= q_vld_reg[j-1];
            end
            out_vld_reg <= q_vld_reg[DIV_STAGES];
        end
    end

    lane_res_t lane_res [4];

    for (genvar i = 0; i < 4; i++) begin : g_lane
        logic signed [31:0] ma [4];
        logic signed [31:0] mb [4];

        for (genvar t = 0; t < 4; t++) begin : g_term
            assign ma[t] = a_arr[TERM_A[i][t]];
            assign mb[t] = b_arr[TERM_B[i][t]];
        end

        qau_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .func    (operand.func),
            .ma      (ma),
            .mb      (mb),
            .neg     (TERM_NEG[i]),
            .a_c     (a_arr[i]),
            .scalar  (1'(i == 0)),
            .divisor (divisor_c),
            .res     (lane_res[i])
        );
    end

    logic [31:0] r_val [4];
    logic [31:0] mag_out;
    logic [1:0]  status_out;

    qau_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk           (clk),
        .en            (en),
        .ctrl          (q_ctrl_reg[DIV_STAGES]),
        .mag           (q_mag_reg[DIV_STAGES]),
        .lane          (lane_res),
        .r_reg         (r_val),
        .magnitude_reg (mag_out),
        .status_reg    (status_out)
    );

    assign result.valid     = out_vld_reg;
    assign result.r_w       = r_val[0];
    assign result.r_x       = r_val[1];
    assign result.r_y       = r_val[2];
    assign result.r_z       = r_val[3];
    assign result.magnitude = mag_out;
    assign result.status    = status_out;

endmodule

FILE: src/qau_checker.sv
`timescale 1ns / 1ps

module qau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        op_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_magnitude,
    input logic [1:0]  res_status
);
    import qau_pkg::*;

    // a held word keeps its valid, status and magnitude
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status)
                                    && $stable(res_magnitude))
        else $error("result word changed while stalled");

    // input side is free whenever the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        op_ready == (!res_valid || res_ready))
        else $error("operand ready does not follow output stall");

    a_rst: assert property (@(posedge clk)
        !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // a zero quaternion never saturates anything
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_magnitude == 32'd0 |-> res_status != ST_SAT)
        else $error("saturation reported for zero length");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_ready      (operand.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_magnitude (result.magnitude),
    .res_status    (result.status)
);
